// File: rtl/lift_sweep_controller_core_assert.svh
`ifndef LIFT_SWEEP_CONTROLLER_CORE_ASSERT_SVH
`define LIFT_SWEEP_CONTROLLER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on aclk, off while aresetn is low.
`define LSC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off while aresetn is low.
`define LSC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/lsc_pkg.sv
package lsc_pkg;

    localparam int ID_W     = 8;
    localparam int FLOOR_W  = 3;
    localparam int RIDERS_W = 3;
    localparam int CFG_W    = 4;

    localparam logic [CFG_W-1:0] FLOORS_IN_USE_RESET = 4'd8;
    localparam int MIN_FLOORS = 2;

    localparam logic [1:0] FUNC_CALL   = 2'd0;
    localparam logic [1:0] FUNC_BOARD  = 2'd1;
    localparam logic [1:0] FUNC_ALIGHT = 2'd2;
    localparam logic [1:0] FUNC_STEP   = 2'd3;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_WAIT_FULL = 2'd1;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd2;
    localparam logic [1:0] STAT_REFUSED   = 2'd3;

    typedef struct packed {
        logic [1:0]         func;
        logic [ID_W-1:0]    person_id;
        logic [FLOOR_W-1:0] at_floor;
        logic [FLOOR_W-1:0] dest_floor;
    } in_item_t;

    typedef struct packed {
        logic [1:0]          status;
        logic [FLOOR_W-1:0]  car_floor;
        logic                heading_up;
        logic                held;
        logic                reversed;
        logic [RIDERS_W-1:0] riders;
    } out_item_t;

    typedef struct packed {
        logic            vld;
        logic [ID_W-1:0] id;
    } wait_word_t;

    typedef struct packed {
        logic capture;
        logic clear;
        logic scan_init;
        logic scan_en;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
        logic need_scan;
        logic scan_done;
    } stat_t;

endpackage

// File: rtl/lsc_ctrl.sv
module lsc_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    output logic          m_valid,
    input  logic          m_ready,
    input  lsc_pkg::stat_t stat,
    output lsc_pkg::cmd_t  cmd
);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_CHECK = 2'd2;
    localparam logic [1:0] S_SCAN  = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       out_vld_reg, out_vld_next;
    logic       out_free;

    assign out_free = !out_vld_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = out_vld_reg;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.capture = s_valid && (state_reg == S_IDLE);
        unique case (state_reg)
            S_CLEAR: begin
                cmd.clear = 1'b1;
                if (stat.clear_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                cmd.scan_init = 1'b1;
                if (stat.need_scan) begin
                    state_next = S_SCAN;
                end else if (out_free) begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_SCAN: begin
                cmd.scan_en = 1'b1;
                if (stat.scan_done && out_free) begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        out_vld_next = out_vld_reg;
        if (cmd.finish) begin
            out_vld_next = 1'b1;
        end else if (m_ready) begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            out_vld_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            out_vld_reg <= out_vld_next;
        end
    end

`include "lift_sweep_controller_core_assert.svh"

    `LSC_ASSERT_IMP(a_finish_slot_free, cmd.finish, out_free, "result overwritten")
    `LSC_ASSERT_IMP(a_valid_from_finish, $rose(out_vld_reg), $past(cmd.finish), "stray result")
    `LSC_ASSERT_NXT(a_accept_to_check, cmd.capture, state_reg == S_CHECK, "item not checked")

endmodule

// File: rtl/lsc_datapath.sv
module lsc_datapath #(
    parameter int FLOORS     = 8,
    parameter int WAIT_SLOTS = 16,
    parameter int CAR_SLOTS  = 4
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  lsc_pkg::cmd_t                   cmd,
    output lsc_pkg::stat_t                  stat,
    input  lsc_pkg::in_item_t               s_item,
    output lsc_pkg::out_item_t              m_item,
    input  logic                            cfg_we,
    input  logic [lsc_pkg::CFG_W-1:0]       cfg_wdata
);

    localparam int DEPTH = FLOORS * WAIT_SLOTS;
    localparam int AW    = $clog2(DEPTH);
    localparam int FLW   = $clog2(FLOORS);
    localparam int SVW   = $clog2(FLOORS + 1);
    localparam int CMPW  = (SVW > lsc_pkg::CFG_W) ? SVW : lsc_pkg::CFG_W;
    localparam int SLW   = $clog2(WAIT_SLOTS + 1);
    localparam int SIW   = (WAIT_SLOTS > 1) ? $clog2(WAIT_SLOTS) : 1;
    localparam int CNTW  = $clog2(CAR_SLOTS + 1);
    localparam int CIW   = (CAR_SLOTS > 1) ? $clog2(CAR_SLOTS) : 1;

    logic [lsc_pkg::CFG_W-1:0]   floors_cfg_reg;
    logic [FLW-1:0]              car_floor_reg, car_floor_next;
    logic                        going_up_reg, going_up_next;
    logic [CAR_SLOTS-1:0]        rider_vld_reg, rider_vld_next;
    logic [lsc_pkg::ID_W-1:0]    rider_id_reg [CAR_SLOTS];
    logic [lsc_pkg::FLOOR_W-1:0] rider_dest_reg [CAR_SLOTS];
    logic [CNTW-1:0]             rider_cnt_reg, rider_cnt_next;
    lsc_pkg::in_item_t           item_reg;
    lsc_pkg::out_item_t          out_reg, out_next;
    logic [AW-1:0]               clr_addr_reg;
    logic [SLW-1:0]              issue_idx_reg;
    logic                        rd_vld_reg;
    logic [SIW-1:0]              rd_slot_reg;
    lsc_pkg::wait_word_t         rd_word_reg;
    lsc_pkg::wait_word_t         wmem [DEPTH];

    logic [CMPW-1:0]      served, top, car_ext, at_ext, dest_ext, scan_floor;
    logic [CAR_SLOTS-1:0] id_match, dest_here;
    logic [CIW-1:0]       match_idx, free_idx;
    logic                 at_ok, room, board_ok, stop_rider, hit, exhausted, scan_hit;
    logic                 need_scan;
    logic [AW-1:0]        base, raddr, waddr;
    logic                 mem_we, mem_re;
    lsc_pkg::wait_word_t  wdata;
    logic                 rider_wr;

    always_comb begin
        served = CMPW'(floors_cfg_reg);
        if (served < CMPW'(lsc_pkg::MIN_FLOORS)) begin
            served = CMPW'(lsc_pkg::MIN_FLOORS);
        end else if (served > CMPW'(FLOORS)) begin
            served = CMPW'(FLOORS);
        end
    end

    assign top      = served - CMPW'(1);
    assign car_ext  = CMPW'(car_floor_reg);
    assign at_ext   = CMPW'(item_reg.at_floor);
    assign dest_ext = CMPW'(item_reg.dest_floor);

    always_comb begin
        match_idx = '0;
        free_idx  = '0;
        for (int i = 0; i < CAR_SLOTS; i++) begin
            id_match[i]  = rider_vld_reg[i] && (rider_id_reg[i] == item_reg.person_id);
            dest_here[i] = rider_vld_reg[i] && (CMPW'(rider_dest_reg[i]) == car_ext);
        end
        for (int i = CAR_SLOTS - 1; i >= 0; i--) begin
            if (id_match[i]) begin
                match_idx = CIW'(i);
            end
            if (!rider_vld_reg[i]) begin
                free_idx = CIW'(i);
            end
        end
    end

    assign at_ok      = at_ext < served;
    assign room       = rider_cnt_reg < CNTW'(CAR_SLOTS);
    assign board_ok   = (at_ext == car_ext) && at_ok && (dest_ext < served) && room;
    assign stop_rider = |dest_here;

    always_comb begin
        case (item_reg.func)
            lsc_pkg::FUNC_CALL:  need_scan = at_ok;
            lsc_pkg::FUNC_BOARD: need_scan = board_ok;
            lsc_pkg::FUNC_STEP:  need_scan = !stop_rider && room;
            default:             need_scan = 1'b0;
        endcase
    end

    assign stat.need_scan = need_scan;

    always_comb begin
        case (item_reg.func)
            lsc_pkg::FUNC_CALL:  hit = !rd_word_reg.vld;
            lsc_pkg::FUNC_BOARD: hit = rd_word_reg.vld && (rd_word_reg.id == item_reg.person_id);
            default:             hit = rd_word_reg.vld;
        endcase
    end

    assign scan_floor     = (item_reg.func == lsc_pkg::FUNC_STEP) ? car_ext : at_ext;
    assign base           = AW'(scan_floor * WAIT_SLOTS);
    assign exhausted      = issue_idx_reg == SLW'(WAIT_SLOTS);
    assign scan_hit       = rd_vld_reg && hit;
    assign stat.scan_done = exhausted || scan_hit;
    assign stat.clear_last = clr_addr_reg == AW'(DEPTH - 1);
    assign mem_re         = cmd.scan_en && !stat.scan_done;
    assign raddr          = base + AW'(issue_idx_reg[SIW-1:0]);

    always_comb begin
        car_floor_next = car_floor_reg;
        going_up_next  = going_up_reg;
        rider_vld_next = rider_vld_reg;
        rider_cnt_next = rider_cnt_reg;
        rider_wr       = 1'b0;
        mem_we         = 1'b0;
        waddr          = base + AW'(rd_slot_reg);
        wdata          = '{vld: 1'b0, id: item_reg.person_id};
        out_next       = out_reg;
        out_next.status   = lsc_pkg::STAT_OK;
        out_next.held     = 1'b0;
        out_next.reversed = 1'b0;
        if (cmd.clear) begin
            mem_we = 1'b1;
            waddr  = clr_addr_reg;
            wdata  = '0;
        end
        if (cmd.finish) begin
            case (item_reg.func)
                lsc_pkg::FUNC_CALL: begin
                    if (!at_ok) begin
                        out_next.status = lsc_pkg::STAT_REFUSED;
                    end else if (scan_hit) begin
                        mem_we    = 1'b1;
                        wdata.vld = 1'b1;
                    end else begin
                        out_next.status = lsc_pkg::STAT_WAIT_FULL;
                    end
                end
                lsc_pkg::FUNC_BOARD: begin
                    if (!board_ok) begin
                        out_next.status = lsc_pkg::STAT_REFUSED;
                    end else if (scan_hit) begin
                        mem_we                   = 1'b1;
                        rider_wr                 = 1'b1;
                        rider_vld_next[free_idx] = 1'b1;
                        rider_cnt_next           = rider_cnt_reg + CNTW'(1);
                    end else begin
                        out_next.status = lsc_pkg::STAT_NOT_FOUND;
                    end
                end
                lsc_pkg::FUNC_ALIGHT: begin
                    if (!(|id_match)) begin
                        out_next.status = lsc_pkg::STAT_NOT_FOUND;
                    end else if (CMPW'(rider_dest_reg[match_idx]) != car_ext) begin
                        out_next.status = lsc_pkg::STAT_REFUSED;
                    end else begin
                        rider_vld_next[match_idx] = 1'b0;
                        rider_cnt_next            = rider_cnt_reg - CNTW'(1);
                    end
                end
                default: begin
                    if (stop_rider || (need_scan && scan_hit)) begin
                        out_next.held = 1'b1;
                    end else if (going_up_reg && (car_ext < top)) begin
                        car_floor_next = car_floor_reg + FLW'(1);
                    end else if (!going_up_reg && (car_floor_reg != '0)) begin
                        car_floor_next = car_floor_reg - FLW'(1);
                    end else begin
                        going_up_next     = !going_up_reg;
                        out_next.reversed = 1'b1;
                    end
                end
            endcase
        end
        out_next.car_floor  = lsc_pkg::FLOOR_W'(car_floor_next);
        out_next.heading_up = going_up_next;
        out_next.riders     = lsc_pkg::RIDERS_W'(rider_cnt_next);
    end

    assign m_item = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            floors_cfg_reg <= lsc_pkg::FLOORS_IN_USE_RESET;
            car_floor_reg  <= '0;
            going_up_reg   <= 1'b1;
            rider_vld_reg  <= '0;
            rider_cnt_reg  <= '0;
            clr_addr_reg   <= '0;
            issue_idx_reg  <= '0;
            rd_vld_reg     <= 1'b0;
        end else begin
            if (cfg_we) begin
                floors_cfg_reg <= cfg_wdata;
            end
            car_floor_reg <= car_floor_next;
            going_up_reg  <= going_up_next;
            rider_vld_reg <= rider_vld_next;
            rider_cnt_reg <= rider_cnt_next;
            if (cmd.clear) begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
            if (cmd.scan_init) begin
                issue_idx_reg <= '0;
                rd_vld_reg    <= 1'b0;
            end else if (mem_re) begin
                issue_idx_reg <= issue_idx_reg + SLW'(1);
                rd_vld_reg    <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            item_reg <= s_item;
        end
        if (cmd.finish) begin
            out_reg <= out_next;
        end
        if (mem_re) begin
            rd_slot_reg <= SIW'(issue_idx_reg);
        end
        if (rider_wr) begin
            rider_id_reg[free_idx]   <= item_reg.person_id;
            rider_dest_reg[free_idx] <= item_reg.dest_floor;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            wmem[waddr] <= wdata;
        end
        if (mem_re) begin
            rd_word_reg <= wmem[raddr];
        end
    end

`include "lift_sweep_controller_core_assert.svh"

    `LSC_ASSERT_IMP(a_rider_count, 1'b1, rider_cnt_reg == CNTW'($countones(rider_vld_reg)), "rider count off")
    `LSC_ASSERT_IMP(a_car_in_range, 1'b1, car_ext < CMPW'(FLOORS), "car beyond floors")
    `LSC_ASSERT_IMP(a_one_mem_access, mem_we, !mem_re, "read and write collide")

endmodule

// File: rtl/lift_sweep_controller_core.sv
// Sweeping elevator controller.
// Input channel s_valid/s_ready/s_item: one operation per item (call, board,
// alight, step). Result channel m_valid/m_ready/m_item: exactly one result per
// item, in order. cfg_we/cfg_wdata writes floors_in_use; write only while idle.
// Alight, refused operations, steps held by a rider and steps with a full car
// are finished from the check state without a scan. Call, board and other
// steps scan the waiting slots of one floor in a memory, one slot per cycle
// after a setup in the check state, ending at the first hit or after
// WAIT_SLOTS slots. s_ready returns when the result is registered.
// Reset: after aresetn the waiting memory is cleared one entry per cycle,
// all FLOORS * WAIT_SLOTS entries, with s_ready low. Car at floor 0 heading up,
// car empty, floors_in_use = 8.
// Stall: the result register holds while m_ready is low; a new item may be
// accepted meanwhile, and its work waits before finishing until the
// previous result has been taken.
module lift_sweep_controller_core #(
    parameter int FLOORS     = 8,
    parameter int WAIT_SLOTS = 16,
    parameter int CAR_SLOTS  = 4
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  lsc_pkg::in_item_t         s_item,
    output logic                      m_valid,
    input  logic                      m_ready,
    output lsc_pkg::out_item_t        m_item,
    input  logic                      cfg_we,
    input  logic [lsc_pkg::CFG_W-1:0] cfg_wdata
);

    lsc_pkg::cmd_t  cmd;
    lsc_pkg::stat_t stat;

    lsc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    lsc_datapath #(
        .FLOORS     (FLOORS),
        .WAIT_SLOTS (WAIT_SLOTS),
        .CAR_SLOTS  (CAR_SLOTS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .s_item    (s_item),
        .m_item    (m_item),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

endmodule

// File: dv/lift_sweep_controller_core_tb.sv
`timescale 1ns / 1ps

module lift_sweep_controller_core_tb;

    localparam int FLOORS     = 8;
    localparam int WAIT_SLOTS = 16;
    localparam int CAR_SLOTS  = 4;
    localparam int HALL_SIZE  = FLOORS * WAIT_SLOTS;

    logic                        aclk;
    logic                        aresetn;
    logic                        s_valid;
    logic                        s_ready;
    lsc_pkg::in_item_t           s_item;
    logic                        m_valid;
    logic                        m_ready = 1'b0;
    lsc_pkg::out_item_t          m_item;
    logic                        cfg_we;
    logic [lsc_pkg::CFG_W-1:0]   cfg_wdata;

    // predicted lift state
    logic [lsc_pkg::CFG_W-1:0]   floors_setting;
    logic [lsc_pkg::FLOOR_W-1:0] lift_floor;
    logic                        lift_up;
    logic [CAR_SLOTS-1:0]        seat_busy;
    logic [lsc_pkg::ID_W-1:0]    seat_person [CAR_SLOTS];
    logic [lsc_pkg::FLOOR_W-1:0] seat_goal [CAR_SLOTS];
    logic [HALL_SIZE-1:0]        hall_busy;
    logic [lsc_pkg::ID_W-1:0]    hall_person [HALL_SIZE];

    lsc_pkg::out_item_t replies_due[$];
    int                 mismatches = 0;
    int                 send_idle_pct = 0;
    int                 stall_pct = 0;
    int                 hold_left = 0;

    lift_sweep_controller_core #(
        .FLOORS(FLOORS),
        .WAIT_SLOTS(WAIT_SLOTS),
        .CAR_SLOTS(CAR_SLOTS)
    ) uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_item(s_item),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_item(m_item),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    always begin
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
        #6;
    end

    function automatic int served_count();
        int n;
        n = int'(floors_setting);
        if (n < lsc_pkg::MIN_FLOORS) n = lsc_pkg::MIN_FLOORS;
        if (n > FLOORS) n = FLOORS;
        return n;
    endfunction

    function automatic int riders_now();
        int n;
        n = 0;
        for (int k = 0; k < CAR_SLOTS; k++)
            if (seat_busy[k]) n++;
        return n;
    endfunction

    function automatic lsc_pkg::out_item_t lift_response(input lsc_pkg::in_item_t it);
        lsc_pkg::out_item_t res;
        int                 srv;
        int                 base;
        int                 here;
        logic               found;
        logic               placed;
        logic               hold_here;
        res = '0;
        srv = served_count();
        base = it.at_floor * WAIT_SLOTS;
        here = lift_floor * WAIT_SLOTS;
        found = 1'b0;
        placed = 1'b0;
        case (it.func)
            lsc_pkg::FUNC_CALL: begin
                if (it.at_floor >= srv) begin
                    res.status = lsc_pkg::STAT_REFUSED;
                end else begin
                    for (int k = 0; k < WAIT_SLOTS; k++) begin
                        if (!found && !hall_busy[base + k]) begin
                            hall_busy[base + k] = 1'b1;
                            hall_person[base + k] = it.person_id;
                            found = 1'b1;
                        end
                    end
                    res.status = found ? lsc_pkg::STAT_OK : lsc_pkg::STAT_WAIT_FULL;
                end
            end
            lsc_pkg::FUNC_BOARD: begin
                if (it.at_floor != lift_floor || it.at_floor >= srv || it.dest_floor >= srv
                        || riders_now() >= CAR_SLOTS) begin
                    res.status = lsc_pkg::STAT_REFUSED;
                end else begin
                    for (int k = 0; k < WAIT_SLOTS; k++) begin
                        if (!found && hall_busy[base + k]
                                && hall_person[base + k] == it.person_id) begin
                            hall_busy[base + k] = 1'b0;
                            found = 1'b1;
                        end
                    end
                    if (found) begin
                        for (int j = 0; j < CAR_SLOTS; j++) begin
                            if (!placed && !seat_busy[j]) begin
                                seat_busy[j] = 1'b1;
                                seat_person[j] = it.person_id;
                                seat_goal[j] = it.dest_floor;
                                placed = 1'b1;
                            end
                        end
                        res.status = lsc_pkg::STAT_OK;
                    end else begin
                        res.status = lsc_pkg::STAT_NOT_FOUND;
                    end
                end
            end
            lsc_pkg::FUNC_ALIGHT: begin
                res.status = lsc_pkg::STAT_NOT_FOUND;
                for (int k = 0; k < CAR_SLOTS; k++) begin
                    if (!found && seat_busy[k] && seat_person[k] == it.person_id) begin
                        found = 1'b1;
                        if (seat_goal[k] != lift_floor) begin
                            res.status = lsc_pkg::STAT_REFUSED;
                        end else begin
                            seat_busy[k] = 1'b0;
                            res.status = lsc_pkg::STAT_OK;
                        end
                    end
                end
            end
            default: begin
                hold_here = 1'b0;
                for (int k = 0; k < CAR_SLOTS; k++)
                    if (seat_busy[k] && seat_goal[k] == lift_floor) hold_here = 1'b1;
                if (riders_now() < CAR_SLOTS) begin
                    for (int k = 0; k < WAIT_SLOTS; k++)
                        if (hall_busy[here + k]) hold_here = 1'b1;
                end
                res.held = hold_here;
                if (!hold_here) begin
                    if (lift_up && lift_floor < srv - 1) begin
                        lift_floor = lift_floor + 3'd1;
                    end else if (!lift_up && lift_floor > 0) begin
                        lift_floor = lift_floor - 3'd1;
                    end else begin
                        lift_up = !lift_up;
                        res.reversed = 1'b1;
                    end
                end
            end
        endcase
        res.car_floor = lift_floor;
        res.heading_up = lift_up;
        res.riders = lsc_pkg::RIDERS_W'(riders_now());
        return res;
    endfunction

    // mostly meaningful operations drawn from the current lift state
    function automatic lsc_pkg::in_item_t pick_item();
        lsc_pkg::in_item_t        it;
        int                       srv;
        int                       r;
        int                       here;
        logic [lsc_pkg::ID_W-1:0] cand[$];
        srv = served_count();
        here = lift_floor * WAIT_SLOTS;
        it.func = lsc_pkg::FUNC_STEP;
        it.person_id = lsc_pkg::ID_W'($urandom_range(255));
        it.at_floor = lsc_pkg::FLOOR_W'($urandom_range(7));
        it.dest_floor = lsc_pkg::FLOOR_W'($urandom_range(7));
        r = $urandom_range(99);
        if (r < 30) begin
            it.func = lsc_pkg::FUNC_STEP;
        end else if (r < 55) begin
            it.func = lsc_pkg::FUNC_CALL;
            if ($urandom_range(1)) it.person_id = lsc_pkg::ID_W'($urandom_range(7));
            if ($urandom_range(9) != 0) it.at_floor = lsc_pkg::FLOOR_W'($urandom_range(srv - 1));
        end else if (r < 75) begin
            it.func = lsc_pkg::FUNC_BOARD;
            for (int k = 0; k < WAIT_SLOTS; k++)
                if (hall_busy[here + k]) cand.push_back(hall_person[here + k]);
            if (cand.size() != 0 && $urandom_range(9) < 8) begin
                it.person_id = cand[$urandom_range(cand.size() - 1)];
                it.at_floor = lift_floor;
                it.dest_floor = lsc_pkg::FLOOR_W'($urandom_range(srv - 1));
            end
        end else if (r < 92) begin
            it.func = lsc_pkg::FUNC_ALIGHT;
            for (int k = 0; k < CAR_SLOTS; k++)
                if (seat_busy[k] && seat_goal[k] == lift_floor) cand.push_back(seat_person[k]);
            if (cand.size() == 0) begin
                for (int k = 0; k < CAR_SLOTS; k++)
                    if (seat_busy[k]) cand.push_back(seat_person[k]);
            end
            if (cand.size() != 0 && $urandom_range(9) < 8)
                it.person_id = cand[$urandom_range(cand.size() - 1)];
        end else begin
            it.func = 2'($urandom_range(3));
        end
        return it;
    endfunction

    function automatic string show(input lsc_pkg::out_item_t v);
        return $sformatf("status=%0d floor=%0d up=%0d held=%0d rev=%0d riders=%0d",
                         v.status, v.car_floor, v.heading_up, v.held, v.reversed, v.riders);
    endfunction

    task automatic send_item(input lsc_pkg::in_item_t it);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        replies_due.push_back(lift_response(it));
    endtask

    task automatic issue(input logic [1:0] func, input int id, input int fl, input int dest);
        lsc_pkg::in_item_t it;
        it.func = func;
        it.person_id = lsc_pkg::ID_W'(id);
        it.at_floor = lsc_pkg::FLOOR_W'(fl);
        it.dest_floor = lsc_pkg::FLOOR_W'(dest);
        send_item(it);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (replies_due.size() != 0) @(posedge aclk);
        repeat (25) @(posedge aclk);
    endtask

    task automatic set_floors(input int v);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= lsc_pkg::CFG_W'(v);
        @(posedge aclk);
        cfg_we    <= 1'b0;
        floors_setting = lsc_pkg::CFG_W'(v);
    endtask

    task automatic test_directed_ops();
        issue(lsc_pkg::FUNC_CALL, 8'hA5, 0, 0);
        issue(lsc_pkg::FUNC_CALL, 8'hA5, 0, 0);
        issue(lsc_pkg::FUNC_CALL, 8'hFF, 7, 7);
        issue(lsc_pkg::FUNC_CALL, 8'h00, 3, 0);
        issue(lsc_pkg::FUNC_BOARD, 8'hA5, 0, 7);
        issue(lsc_pkg::FUNC_BOARD, 8'h5A, 0, 2);
        issue(lsc_pkg::FUNC_BOARD, 8'hFF, 7, 1);
        issue(lsc_pkg::FUNC_BOARD, 8'hA5, 0, 7);
        issue(lsc_pkg::FUNC_ALIGHT, 8'hA5, 0, 0);
        issue(lsc_pkg::FUNC_ALIGHT, 8'h11, 7, 7);
        repeat (4) issue(lsc_pkg::FUNC_STEP, 8'h00, 0, 0);
        issue(lsc_pkg::FUNC_BOARD, 8'h00, 3, 0);
        repeat (5) issue(lsc_pkg::FUNC_STEP, 8'hFF, 7, 7);
        issue(lsc_pkg::FUNC_ALIGHT, 8'hA5, 0, 0);
        issue(lsc_pkg::FUNC_ALIGHT, 8'hA5, 0, 0);
        issue(lsc_pkg::FUNC_BOARD, 8'hFF, 7, 6);
        repeat (3) issue(lsc_pkg::FUNC_STEP, 8'h00, 0, 0);
        issue(lsc_pkg::FUNC_ALIGHT, 8'hFF, 0, 0);
    endtask

    task automatic test_floor_limits();
        set_floors(0);
        issue(lsc_pkg::FUNC_STEP, 8'h00, 0, 0);
        issue(lsc_pkg::FUNC_CALL, 8'h22, 2, 0);
        issue(lsc_pkg::FUNC_CALL, 8'h22, 1, 0);
        issue(lsc_pkg::FUNC_BOARD, 8'h22, 1, 0);
        set_floors(15);
        repeat (5) issue(lsc_pkg::FUNC_STEP, 8'h00, 0, 0);
        issue(lsc_pkg::FUNC_BOARD, 8'h22, 1, 7);
        repeat (2) issue(lsc_pkg::FUNC_STEP, 8'h00, 0, 0);
        issue(lsc_pkg::FUNC_ALIGHT, 8'h00, 0, 0);
        repeat (7) issue(lsc_pkg::FUNC_STEP, 8'h00, 0, 0);
        set_floors(1);
        repeat (2) issue(lsc_pkg::FUNC_STEP, 8'h00, 0, 0);
        issue(lsc_pkg::FUNC_BOARD, 8'h22, 5, 0);
        issue(lsc_pkg::FUNC_ALIGHT, 8'h22, 5, 0);
        set_floors(8);
    endtask

    task automatic test_output_backpressure();
        wait_idle();
        send_idle_pct = 0;
        stall_pct = 0;
        hold_left = 400;
        repeat (40) send_item(pick_item());
    endtask

    task automatic test_random_traffic(input int count, input int send_pct, input int recv_pct,
                                       input int floors);
        lsc_pkg::in_item_t it;
        int                done;
        set_floors(floors);
        send_idle_pct = send_pct;
        stall_pct = recv_pct;
        done = 0;
        while (done < count) begin
            if ($urandom_range(149) == 0) begin
                // overfill one floor's waiting slots
                it.func = lsc_pkg::FUNC_CALL;
                it.at_floor = lsc_pkg::FLOOR_W'($urandom_range(served_count() - 1));
                it.dest_floor = lsc_pkg::FLOOR_W'($urandom_range(7));
                repeat (18) begin
                    it.person_id = lsc_pkg::ID_W'($urandom_range(255));
                    send_item(it);
                end
                done += 18;
            end else begin
                send_item(pick_item());
                done++;
            end
        end
    endtask

    always @(posedge aclk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        lsc_pkg::out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (replies_due.size() == 0) begin
                if (mismatches < 10) $display("unexpected result: %s", show(m_item));
                mismatches++;
            end else begin
                want = replies_due.pop_front();
                if (m_item.status !== want.status || m_item.car_floor !== want.car_floor
                        || m_item.heading_up !== want.heading_up || m_item.held !== want.held
                        || m_item.reversed !== want.reversed || m_item.riders !== want.riders) begin
                    if (mismatches < 10) begin
                        $display("mismatch at %0t", $realtime);
                        $display("  expected %s", show(want));
                        $display("  actual   %s", show(m_item));
                    end
                    mismatches++;
                end
            end
        end
    end

    initial begin
        #10_000_000;
        $display("lift_sweep_controller_core_tb NOT OK");
        $finish;
    end

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_item = '0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        floors_setting = lsc_pkg::FLOORS_IN_USE_RESET;
        lift_floor = '0;
        lift_up = 1'b1;
        seat_busy = '0;
        hall_busy = '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed_ops();
        test_floor_limits();
        test_output_backpressure();
        test_random_traffic(300, 0, 0, 8);
        test_random_traffic(350, 73, 0, 3);
        test_random_traffic(350, 0, 73, 15);
        test_random_traffic(300, 15, 15, 1);
        test_random_traffic(300, 0, 0, 6);
        test_random_traffic(200, 15, 15, 5);
        wait_idle();
        if (mismatches == 0 && replies_due.size() == 0) begin
            $display("lift_sweep_controller_core_tb OK");
        end else begin
            $display("lift_sweep_controller_core_tb NOT OK");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl
rtl/lsc_pkg.sv
rtl/lsc_ctrl.sv
rtl/lsc_datapath.sv
rtl/lift_sweep_controller_core.sv
dv/lift_sweep_controller_core_tb.sv
